FILE: src/sha1bc_pkg.sv
// Shared types, constants and round helpers for the SHA-1 block compression core.
// Used by every module in src; depends on nothing.
package sha1bc_pkg;

  localparam int unsigned WordW      = 32;
  localparam int unsigned ChainWords = 5;
  localparam int unsigned BlockWords = 16;
  localparam int unsigned AddrW      = $clog2(BlockWords);
  localparam int unsigned Rounds     = 80;
  localparam int unsigned RoundW     = $clog2(Rounds);
  localparam int unsigned CfgAddrW   = 5;
  localparam int unsigned IdxW       = 3;

  localparam logic [WordW-1:0] K0 = 32'h5A82_7999;
  localparam logic [WordW-1:0] K1 = 32'h6ED9_EBA1;
  localparam logic [WordW-1:0] K2 = 32'h8F1B_BCDC;
  localparam logic [WordW-1:0] K3 = 32'hCA62_C1D6;

  localparam logic [ChainWords-1:0][WordW-1:0] ResetIv = {
    32'hC3D2_E1F0, 32'h1032_5476, 32'h98BA_DCFE, 32'hEFCD_AB89, 32'h6745_2301
  };

  typedef logic [ChainWords-1:0][WordW-1:0] chain_t;

  typedef enum logic [1:0] {
    GRP_CH  = 2'd0,
    GRP_XOR = 2'd1,
    GRP_MAJ = 2'd2,
    GRP_PAR = 2'd3
  } round_grp_t;

  typedef enum logic [2:0] {
    CORE_IDLE,
    CORE_PRIME,
    CORE_ISSUE,
    CORE_ROUND,
    CORE_DONE
  } core_state_t;

  typedef enum logic {
    TOP_COLLECT,
    TOP_COMPRESS
  } top_state_t;

  typedef struct packed {
    logic start;
    logic ack;
  } core_ctl_t;

  typedef struct packed {
    logic done;
  } core_sts_t;

  function automatic round_grp_t round_group(input logic [RoundW-1:0] r);
    round_grp_t g;
    if (r < 7'd20) begin
      g = GRP_CH;
    end else if (r < 7'd40) begin
      g = GRP_XOR;
    end else if (r < 7'd60) begin
      g = GRP_MAJ;
    end else begin
      g = GRP_PAR;
    end
    return g;
  endfunction

  function automatic logic [WordW-1:0] round_k(input round_grp_t g);
    logic [WordW-1:0] k;
    case (g)
      GRP_CH:  k = K0;
      GRP_XOR: k = K1;
      GRP_MAJ: k = K2;
      GRP_PAR: k = K3;
      default: k = K0;
    endcase
    return k;
  endfunction

  function automatic logic [WordW-1:0] round_f(input round_grp_t g,
                                               input logic [WordW-1:0] b,
                                               input logic [WordW-1:0] c,
                                               input logic [WordW-1:0] d);
    logic [WordW-1:0] f;
    case (g)
      GRP_CH:  f = d ^ (b & (c ^ d));
      GRP_MAJ: f = (b & c) | (d & (b | c));
      default: f = b ^ c ^ d;
    endcase
    return f;
  endfunction

endpackage

FILE: src/sha1bc_wmem.sv
// Message schedule store: 16 words, one write port and two registered read ports.
// Depends on sha1bc_pkg for widths.
module sha1bc_wmem (
  input  logic                              clk,
  input  logic                              we,
  input  logic [sha1bc_pkg::AddrW-1:0]      waddr,
  input  logic [sha1bc_pkg::WordW-1:0]      wdata,
  input  logic [sha1bc_pkg::AddrW-1:0]      raddr0,
  input  logic [sha1bc_pkg::AddrW-1:0]      raddr1,
  output logic [sha1bc_pkg::WordW-1:0]      rdata0,
  output logic [sha1bc_pkg::WordW-1:0]      rdata1
);

  logic [sha1bc_pkg::WordW-1:0] mem [sha1bc_pkg::BlockWords];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

FILE: src/sha1bc_core.sv
// Round sequencer and datapath: runs the 80 SHA-1 rounds over the schedule store.
// Depends on sha1bc_pkg and instantiates sha1bc_wmem.
module sha1bc_core (
  input  logic                             clk,
  input  logic                             rst,
  input  sha1bc_pkg::core_ctl_t            ctl,
  input  logic                             in_we,
  input  logic [sha1bc_pkg::AddrW-1:0]     in_addr,
  input  logic [sha1bc_pkg::WordW-1:0]     in_data,
  input  sha1bc_pkg::chain_t               chain_in,
  output sha1bc_pkg::core_sts_t            sts,
  output sha1bc_pkg::chain_t               work
);

  sha1bc_pkg::core_state_t state, state_next;
  logic [sha1bc_pkg::RoundW-1:0] rnd;
  logic [sha1bc_pkg::WordW-1:0]  x1;
  logic [sha1bc_pkg::WordW-1:0]  ek;

  logic                          mem_we;
  logic [sha1bc_pkg::AddrW-1:0]  mem_waddr;
  logic [sha1bc_pkg::WordW-1:0]  mem_wdata;
  logic [sha1bc_pkg::AddrW-1:0]  raddr0, raddr1;
  logic [sha1bc_pkg::WordW-1:0]  rdata0, rdata1;

  logic [sha1bc_pkg::AddrW-1:0]  rlo;
  logic                          expand;
  logic [sha1bc_pkg::WordW-1:0]  wx, wt, t, a_rot;
  sha1bc_pkg::round_grp_t        grp;

  sha1bc_wmem u_wmem (
    .clk    (clk),
    .we     (mem_we),
    .waddr  (mem_waddr),
    .wdata  (mem_wdata),
    .raddr0 (raddr0),
    .raddr1 (raddr1),
    .rdata0 (rdata0),
    .rdata1 (rdata1)
  );

  assign rlo    = rnd[sha1bc_pkg::AddrW-1:0];
  assign expand = (rnd >= 7'(sha1bc_pkg::BlockWords));
  assign grp    = sha1bc_pkg::round_group(rnd);

  // The second read pair carries w[r+2] and w[r]; the first pair was folded into x1.
  assign wx    = x1 ^ rdata0 ^ rdata1;
  assign wt    = expand ? {wx[30:0], wx[31]} : rdata1;
  assign a_rot = {work[0][26:0], work[0][31:27]};
  assign t     = a_rot + sha1bc_pkg::round_f(grp, work[1], work[2], work[3]) + ek + wt;

  always_comb begin
    state_next = state;
    case (state)
      sha1bc_pkg::CORE_IDLE:  if (ctl.start) state_next = sha1bc_pkg::CORE_PRIME;
      sha1bc_pkg::CORE_PRIME: state_next = sha1bc_pkg::CORE_ISSUE;
      sha1bc_pkg::CORE_ISSUE: state_next = sha1bc_pkg::CORE_ROUND;
      sha1bc_pkg::CORE_ROUND: begin
        if (rnd == 7'(sha1bc_pkg::Rounds - 1)) begin
          state_next = sha1bc_pkg::CORE_DONE;
        end else begin
          state_next = sha1bc_pkg::CORE_ISSUE;
        end
      end
      sha1bc_pkg::CORE_DONE:  if (ctl.ack) state_next = sha1bc_pkg::CORE_IDLE;
      default:                state_next = sha1bc_pkg::CORE_IDLE;
    endcase
  end

  always_comb begin
    raddr0    = rlo + 4'd13;
    raddr1    = rlo + 4'd8;
    mem_we    = in_we;
    mem_waddr = in_addr;
    mem_wdata = in_data;
    sts.done  = 1'b0;
    case (state)
      sha1bc_pkg::CORE_ISSUE: begin
        raddr0 = rlo + 4'd2;
        raddr1 = rlo;
      end
      sha1bc_pkg::CORE_ROUND: begin
        // Fetch the first pair for the next round while this one retires.
        raddr0    = rlo + 4'd14;
        raddr1    = rlo + 4'd9;
        mem_we    = expand;
        mem_waddr = rlo;
        mem_wdata = wt;
      end
      sha1bc_pkg::CORE_DONE: sts.done = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sha1bc_pkg::CORE_IDLE;
      rnd   <= '0;
    end else begin
      state <= state_next;
      if (state == sha1bc_pkg::CORE_IDLE && ctl.start) begin
        rnd <= '0;
      end else if (state == sha1bc_pkg::CORE_ROUND) begin
        rnd <= rnd + 7'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      sha1bc_pkg::CORE_IDLE: begin
        if (ctl.start) work <= chain_in;
      end
      sha1bc_pkg::CORE_ISSUE: begin
        x1 <= rdata0 ^ rdata1;
        ek <= work[4] + sha1bc_pkg::round_k(grp);
      end
      sha1bc_pkg::CORE_ROUND: begin
        work[4] <= work[3];
        work[3] <= work[2];
        work[2] <= {work[1][1:0], work[1][31:2]};
        work[1] <= work[0];
        work[0] <= t;
      end
      default: ;
    endcase
  end

endmodule

FILE: src/sha1_block_compress.sv
// Top level of the SHA-1 block compression core: stream ports, APB registers,
// chaining value and digest output buffer. Depends on sha1bc_pkg and sha1bc_core.
//
//  Channel   Direction  Transaction carries
//  s_*       in         one message word (tdata) and the new-chain flag (tuser)
//  m_*       out        one digest word (tdata), its index (tuser), last flag (tlast)
//  APB       in         write or read of init_h0..init_h4 at byte address 4*i
//
// Words are taken one per cycle while collecting (s_tready is low during compression)
// until a block holds sixteen. The round sequencer then primes, runs each of the
// 80 rounds as an issue step and a round step (the schedule store has two read
// ports and every expanded round needs four words), and hands off its result.
// The five digest words leave from a buffer of their own, so the next block
// collects meanwhile.
// Reset (rst, synchronous) restores the standard initial value in the registers
// and clears all control state; the schedule store is not cleared.
// A stalled m_tready holds the digest buffer and, once the next block is
// compressed, keeps the sequencer waiting with its result.
module sha1_block_compress (
  input  logic                              clk,
  input  logic                              rst,
  // Input stream.
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [31:0]                       s_tdata,   // [31:0] message_word
  input  logic [0:0]                        s_tuser,   // [0] new_chain
  // Output stream.
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [31:0]                       m_tdata,   // [31:0] digest_word
  output logic [2:0]                        m_tuser,   // [2:0] digest_index
  output logic                              m_tlast,   // last_word
  // Configuration port.
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [sha1bc_pkg::CfgAddrW-1:0]   paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  sha1bc_pkg::top_state_t state, state_next;

  sha1bc_pkg::chain_t init_regs;     // configuration registers init_h0..init_h4
  sha1bc_pkg::chain_t chain_value;   // running chaining value
  sha1bc_pkg::chain_t digest_buf;    // words waiting to leave on m_*
  sha1bc_pkg::chain_t chain_sum;
  sha1bc_pkg::chain_t work;

  logic [sha1bc_pkg::AddrW-1:0] word_count;
  logic                         chain_started;
  logic                         out_busy;
  logic [sha1bc_pkg::IdxW-1:0]  out_idx;

  logic [sha1bc_pkg::IdxW-1:0]  cfg_idx;
  logic                         cfg_we;

  logic                         in_acc, out_acc, restart, block_full, finish;
  logic [sha1bc_pkg::AddrW-1:0] wr_slot;

  sha1bc_pkg::core_ctl_t ctl;
  sha1bc_pkg::core_sts_t sts;

  // APB: always ready; register i sits at byte address 4*i, higher indexes ignored.
  assign pready  = 1'b1;
  assign cfg_idx = paddr[sha1bc_pkg::CfgAddrW-1:2];
  assign cfg_we  = psel && penable && pwrite;

  always_comb begin
    prdata = '0;
    if (cfg_idx < 3'(sha1bc_pkg::ChainWords)) begin
      prdata = init_regs[cfg_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      init_regs <= sha1bc_pkg::ResetIv;
    end else if (cfg_we && cfg_idx < 3'(sha1bc_pkg::ChainWords)) begin
      init_regs[cfg_idx] <= pwdata;
    end
  end

  // Input side. A set flag, or the very first word after reset, opens a new chain:
  // earlier words of the block are dropped and this word lands in slot zero.
  assign s_tready   = (state == sha1bc_pkg::TOP_COLLECT);
  assign in_acc     = s_tvalid && s_tready;
  assign restart    = s_tuser[0] || !chain_started;
  assign wr_slot    = restart ? '0 : word_count;
  assign block_full = (wr_slot == 4'(sha1bc_pkg::BlockWords - 1));

  // The sequencer's result is taken only once the digest buffer has drained.
  assign finish = (state == sha1bc_pkg::TOP_COMPRESS) && sts.done && !out_busy;

  assign ctl.start = in_acc && block_full;
  assign ctl.ack   = finish;

  sha1bc_core u_core (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .in_we    (in_acc),
    .in_addr  (wr_slot),
    .in_data  (s_tdata),
    .chain_in (chain_value),
    .sts      (sts),
    .work     (work)
  );

  always_comb begin
    for (int k = 0; k < sha1bc_pkg::ChainWords; k++) begin
      chain_sum[k] = chain_value[k] + work[k];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      sha1bc_pkg::TOP_COLLECT:  if (ctl.start) state_next = sha1bc_pkg::TOP_COMPRESS;
      sha1bc_pkg::TOP_COMPRESS: if (finish) state_next = sha1bc_pkg::TOP_COLLECT;
      default:                  state_next = sha1bc_pkg::TOP_COLLECT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= sha1bc_pkg::TOP_COLLECT;
      word_count    <= '0;
      chain_started <= 1'b0;
    end else begin
      state <= state_next;
      if (in_acc) begin
        chain_started <= 1'b1;
        word_count    <= wr_slot + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain_value <= '0;
    end else if (in_acc && restart) begin
      chain_value <= init_regs;
    end else if (finish) begin
      chain_value <= chain_sum;
    end
  end

  // Output side: five transactions per block, index zero first.
  assign out_acc  = m_tvalid && m_tready;
  assign m_tvalid = out_busy;
  assign m_tdata  = digest_buf[out_idx];
  assign m_tuser  = out_idx;
  assign m_tlast  = (out_idx == 3'(sha1bc_pkg::ChainWords - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_busy <= 1'b0;
      out_idx  <= '0;
    end else if (finish) begin
      out_busy <= 1'b1;
      out_idx  <= '0;
    end else if (out_acc) begin
      if (m_tlast) begin
        out_busy <= 1'b0;
      end
      out_idx <= out_idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      digest_buf <= chain_sum;
    end
  end

endmodule
